// ===== rtl/core/s2x3x_pkg.sv =====
// Shared types and constants for the Scale2x/Scale3x pixel upscaler.
`default_nettype none
package s2x3x_pkg;
  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 1024;
  localparam logic [1:0] RegScale  = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;
  localparam logic [1:0] FactorThree = 2'd3;
  localparam logic [1:0] FactorResetVal = 2'd2;
  localparam logic [10:0] WidthResetVal  = 11'd320;
  localparam logic [10:0] HeightResetVal = 11'd200;

  // Window and position handed from the read stage to the output sequencer.
  typedef struct packed {
    logic [8:0][31:0] win;
    logic [11:0]      cr;
    logic [11:0]      cc;
    logic             three;
  } job_t;
endpackage
`default_nettype wire

// ===== rtl/core/scale2x_scale3x_pixel_upscaler.sv =====
// Top level of the Scale2x/Scale3x streaming pixel upscaler.
// An accepted pixel beat reads both line stores into stage 1; when stage 1 advances it shifts
// the window and hands a job to the output sequencer, whose held job drives the result beats.
// The sequencer emits a beat per cycle while out_ready is high: 4 at factor 2, 9 at factor 3;
// stage 1 can hold the next source pixel meanwhile, and beats that emit nothing do not wait.
// Synchronous reset clears registers, window, counters and pipeline; not the line stores.
`default_nettype none
module scale2x_scale3x_pixel_upscaler #(
  parameter int MAX_WIDTH  = s2x3x_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = s2x3x_pkg::MaxHeightDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [31:0] pixel_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_pixel,
  output logic [11:0]      out_col,
  output logic [11:0]      out_row,
  output logic             last_of_run
);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
  localparam logic [12:0] MaxH = 13'(MAX_HEIGHT);

  logic [1:0]  scale_factor;
  logic [10:0] frame_width, frame_height;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= s2x3x_pkg::FactorResetVal;
      frame_width  <= s2x3x_pkg::WidthResetVal;
      frame_height <= s2x3x_pkg::HeightResetVal;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        s2x3x_pkg::RegScale:  scale_factor <= pwdata[1:0];
        s2x3x_pkg::RegWidth:  frame_width  <= pwdata[10:0];
        s2x3x_pkg::RegHeight: frame_height <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      s2x3x_pkg::RegScale:  prdata = {30'd0, scale_factor};
      s2x3x_pkg::RegWidth:  prdata = {21'd0, frame_width};
      s2x3x_pkg::RegHeight: prdata = {21'd0, frame_height};
      default:              prdata = 32'd0;
    endcase
  end

  // Clamped frame size, both held in 12 bits.
  logic [11:0] w, h;
  always_comb begin
    w = {1'b0, frame_width};
    if (w < 12'd2) w = 12'd2; else if ({1'b0, w} > MaxW) w = MaxW[11:0];
    h = {1'b0, frame_height};
    if (h < 12'd2) h = 12'd2; else if ({1'b0, h} > MaxH) h = MaxH[11:0];
  end

  // Raster position of the next input beat.
  logic [11:0] col, row;
  logic [AW-1:0] addr;
  assign addr = col[AW-1:0];

  // Stage 1: the accepted beat waits here while the stores are read.
  logic        s1_valid;
  logic [31:0] s1_v;
  logic [AW-1:0] s1_addr;
  logic        s1_emit;
  logic [11:0] s1_cr, s1_cc;

  logic [31:0] upper_mem [MAX_WIDTH];
  logic [31:0] middle_mem [MAX_WIDTH];
  logic [31:0] uo_rd, mo_rd;
  logic [31:0] uo_cur, mo_cur;

  // Output sequencer.
  logic        job_valid;
  s2x3x_pkg::job_t job;
  logic [3:0]  seq;
  logic        out_busy;

  logic take, valid_item, s1_adv;
  // The stage-1 beat moves on when it emits no job or the sequencer is free or finishes this cycle.
  logic seq_done;
  assign seq_done = out_valid && out_ready && last_of_run;
  assign s1_adv   = s1_valid && (!s1_emit || !job_valid || seq_done);
  assign in_ready = !s1_valid || s1_adv;
  assign take     = in_valid && in_ready;
  assign valid_item = (action ? (row >= h) : (row < h)) && (col < w);

  always_ff @(posedge clk) begin
    if (take && valid_item) begin
      uo_rd <= upper_mem[addr];
      mo_rd <= middle_mem[addr];
    end
    if (s1_adv) begin
      upper_mem[s1_addr]  <= mo_cur;
      middle_mem[s1_addr] <= s1_v;
    end
  end

  assign uo_cur = uo_rd;
  assign mo_cur = mo_rd;
  // Within a frame consecutive beats use different columns. Column 0 can be read while
  // stage 1 writes it only when a frame restarts after its last drain; the values read
  // then feed only the top row of the new frame, where edge copying replaces them.

  logic [8:0][31:0] win;

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      col <= 12'd0;
      row <= 12'd0;
    end else if (take && valid_item) begin
      if (row > h) begin
        col <= 12'd0; row <= 12'd0;
      end else if (col + 12'd1 >= w) begin
        col <= 12'd0; row <= row + 12'd1;
      end else begin
        col <= col + 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      if (s1_adv) s1_valid <= 1'b0;
      if (take && valid_item) s1_valid <= 1'b1;
    end
    if (take && valid_item) begin
      s1_v    <= action ? 32'd0 : pixel_value;
      s1_addr <= addr;
      s1_emit <= (col >= 12'd1 && row >= 12'd1) || (col == 12'd0 && row >= 12'd2);
      s1_cr   <= (col >= 12'd1) ? row - 12'd1 : row - 12'd2;
      s1_cc   <= (col >= 12'd1) ? col - 12'd1 : w - 12'd1;
    end
  end

  // Window shift and edge replication for the new job.
  logic [8:0][31:0] nw, ew;
  always_comb begin
    nw[0] = win[1]; nw[1] = win[2]; nw[2] = uo_cur;
    nw[3] = win[4]; nw[4] = win[5]; nw[5] = mo_cur;
    nw[6] = win[7]; nw[7] = win[8]; nw[8] = s1_v;
    ew = nw;
    if (s1_cr == 12'd0) begin ew[0] = ew[3]; ew[1] = ew[4]; ew[2] = ew[5]; end
    if (s1_cr == h - 12'd1) begin ew[6] = ew[3]; ew[7] = ew[4]; ew[8] = ew[5]; end
    if (s1_cc == 12'd0) begin ew[0] = ew[1]; ew[3] = ew[4]; ew[6] = ew[7]; end
    if (s1_cc == w - 12'd1) begin ew[2] = ew[1]; ew[5] = ew[4]; ew[8] = ew[7]; end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
      job_valid <= 1'b0;
      seq <= 4'd0;
    end else begin
      if (s1_adv) win <= nw;
      if (seq_done) job_valid <= 1'b0;
      else if (out_valid && out_ready) seq <= seq + 4'd1;
      if (s1_adv && s1_emit) begin
        job_valid <= 1'b1;
        seq <= 4'd0;
      end else if (seq_done) begin
        seq <= 4'd0;
      end
    end
    if (s1_adv && s1_emit) begin
      job.win   <= ew;
      job.cr    <= s1_cr;
      job.cc    <= s1_cc;
      job.three <= (scale_factor == s2x3x_pkg::FactorThree);
    end
  end
  assign out_busy = job_valid;
  assign out_valid = out_busy;

  // Rule evaluation on the held window.
  logic [31:0] pa, pb, pc, pd, pe, pf, pg, ph, pi;
  assign {pi, ph, pg, pf, pe, pd, pc, pb, pa} = job.win;
  logic [8:0][31:0] px;
  always_comb begin
    px = {9{pe}};
    if (pb != ph && pd != pf) begin
      if (!job.three) begin
        px[0] = (pd == pb) ? pd : pe;
        px[1] = (pb == pf) ? pf : pe;
        px[2] = (pd == ph) ? pd : pe;
        px[3] = (ph == pf) ? pf : pe;
      end else begin
        px[0] = (pd == pb) ? pd : pe;
        px[1] = ((pd == pb && pe != pc) || (pb == pf && pe != pa)) ? pb : pe;
        px[2] = (pb == pf) ? pf : pe;
        px[3] = ((pd == pb && pe != pg) || (pd == ph && pe != pa)) ? pd : pe;
        px[5] = ((pb == pf && pe != pi) || (ph == pf && pe != pc)) ? pf : pe;
        px[6] = (pd == ph) ? pd : pe;
        px[7] = ((pd == ph && pe != pi) || (ph == pf && pe != pg)) ? ph : pe;
        px[8] = (ph == pf) ? pf : pe;
      end
    end
  end

  logic [1:0] si, sj;
  always_comb begin
    if (job.three) begin
      si = (seq >= 4'd6) ? 2'd2 : (seq >= 4'd3) ? 2'd1 : 2'd0;
      sj = 2'(seq - {si, 1'b0} - {2'd0, si});
    end else begin
      si = {1'b0, seq[1]};
      sj = {1'b0, seq[0]};
    end
  end

  logic [11:0] base_c, base_r;
  assign base_c = job.three ? (job.cc + {job.cc[10:0], 1'b0}) : {job.cc[10:0], 1'b0};
  assign base_r = job.three ? (job.cr + {job.cr[10:0], 1'b0}) : {job.cr[10:0], 1'b0};
  assign out_pixel   = px[seq];
  assign out_col     = base_c + {10'd0, sj};
  assign out_row     = base_r + {10'd0, si};
  assign last_of_run = job.three ? (seq == 4'd8) : (seq == 4'd3);
endmodule
`default_nettype wire
